/* sv/fat_volume_geometry_check_unit_defines.svh */
// ----------------------------------------------------------------------------
// FAT volume geometry check - assertion macros
// Concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef FAT_VOLUME_GEOMETRY_CHECK_UNIT_DEFINES_SVH
`define FAT_VOLUME_GEOMETRY_CHECK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define FVGC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fvgc assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define FVGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fvgc assertion failed");
`else
`define FVGC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FVGC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/fvgc_pkg.sv */
// ----------------------------------------------------------------------------
// fvgc_pkg
// Types and constants shared by the FAT volume geometry check blocks.
// ----------------------------------------------------------------------------
package fvgc_pkg;

  localparam int IN_BITS  = 176;
  localparam int OUT_BITS = 144;

  localparam logic [7:0]  JMP_SHORT    = 8'hEB;
  localparam logic [7:0]  JMP_NOP      = 8'h90;
  localparam logic [7:0]  JMP_NEAR     = 8'hE9;
  localparam logic [15:0] SECTOR_BYTES = 16'd512;
  localparam logic [21:0] ENTRY_BYTES  = 22'd32;
  localparam logic [31:0] LIMIT_FAT12  = 32'd4085;
  localparam logic [31:0] LIMIT_FAT16  = 32'd65525;

  // quotient bits resolved per divider stage, and number of stages
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES         = 32 / DIV_BITS_PER_STAGE;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_JUMP   = 2'd1,
    ST_BAD_SECTOR = 2'd2,
    ST_BAD_GEOM   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FS_FAT12 = 2'd0,
    FS_FAT16 = 2'd1,
    FS_FAT32 = 2'd2
  } fs_type_t;

  // classified item as it sits in the queue; all fields but status zero on failure
  typedef struct packed {
    status_t     status;
    logic [31:0] total;
    logic [31:0] first_data;
    logic [12:0] root;
    logic [7:0]  spc;
    logic [15:0] rsvd;
    logic [31:0] dividend;  // becomes the quotient as the divider runs
  } entry_t;

  typedef struct packed {
    entry_t     info;
    logic [7:0] rem;
  } div_t;

endpackage

/* sv/fvgc_front.sv */
// ----------------------------------------------------------------------------
// fvgc_front
// Accepts boot-sector records, checks jump, sector size and geometry, selects
// sizes, forms the overhead and the data sector count, and pushes to the queue.
// ----------------------------------------------------------------------------
module fvgc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // jump_byte0, jump_byte2, bytes_per_sector, root_entry_count, fat_size_short,
  // fat_size_long, total_sectors_short, total_sectors_long,
  // reserved_sector_count, fat_copies, sectors_per_cluster
  input  logic [fvgc_pkg::IN_BITS-1:0] in_tdata,
  input  logic                        q_full,
  output logic                        push,
  output fvgc_pkg::entry_t            push_data
);
  import fvgc_pkg::*;

  logic [7:0]  jb0, jb2, copies, spc;
  logic [15:0] bps, rec, fs16, ts16, rsvd;
  logic [31:0] fs32, ts32, fat_secs, total;
  logic [21:0] rec_bytes;
  logic [12:0] root;
  logic        jump_ok, accept;
  status_t     status_pre;

  logic        f_valid_r, f_valid_nxt;
  status_t     f_status_r;
  logic [31:0] f_total_r;
  logic [39:0] f_prod_r;
  logic [16:0] f_base_r;
  logic [12:0] f_root_r;
  logic [7:0]  f_spc_r;
  logic [15:0] f_rsvd_r;

  logic [40:0] overhead;
  logic        geom_bad;
  status_t     status_fin;

  assign jb0    = in_tdata[7:0];
  assign jb2    = in_tdata[15:8];
  assign bps    = in_tdata[31:16];
  assign rec    = in_tdata[47:32];
  assign fs16   = in_tdata[63:48];
  assign fs32   = in_tdata[95:64];
  assign ts16   = in_tdata[111:96];
  assign ts32   = in_tdata[143:112];
  assign rsvd   = in_tdata[159:144];
  assign copies = in_tdata[167:160];
  assign spc    = in_tdata[175:168];

  assign jump_ok   = ((jb0 == JMP_SHORT) && (jb2 == JMP_NOP)) || (jb0 == JMP_NEAR);
  assign fat_secs  = (fs16 != 16'd0) ? {16'd0, fs16} : fs32;
  assign total     = (ts16 != 16'd0) ? {16'd0, ts16} : ts32;
  assign rec_bytes = {6'd0, rec} * ENTRY_BYTES;

  always_comb begin
    root = 13'((rec_bytes + 22'(SECTOR_BYTES - 16'd1)) / 22'(SECTOR_BYTES));
    if (!jump_ok) begin
      status_pre = ST_BAD_JUMP;
    end else if (bps != SECTOR_BYTES) begin
      status_pre = ST_BAD_SECTOR;
    end else begin
      status_pre = ST_OK;
    end
  end

  assign in_tready   = !f_valid_r || !q_full;
  assign accept      = in_tvalid && in_tready;
  assign push        = f_valid_r && !q_full;
  assign f_valid_nxt = accept ? 1'b1 : (push ? 1'b0 : f_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_status_r <= status_pre;
      f_total_r  <= total;
      f_prod_r   <= {32'd0, copies} * {8'd0, fat_secs};
      f_base_r   <= {1'b0, rsvd} + {4'd0, root};
      f_root_r   <= root;
      f_spc_r    <= spc;
      f_rsvd_r   <= rsvd;
    end
  end

  assign overhead = {1'b0, f_prod_r} + {24'd0, f_base_r};
  assign geom_bad = (f_spc_r == 8'd0) || (overhead[40:32] != 9'd0) ||
                    (overhead[31:0] > f_total_r);

  always_comb begin
    if (f_status_r != ST_OK) begin
      status_fin = f_status_r;
    end else if (geom_bad) begin
      status_fin = ST_BAD_GEOM;
    end else begin
      status_fin = ST_OK;
    end
    push_data        = '0;
    push_data.status = status_fin;
    if (status_fin == ST_OK) begin
      push_data.total      = f_total_r;
      push_data.first_data = overhead[31:0];
      push_data.root       = f_root_r;
      push_data.spc        = f_spc_r;
      push_data.rsvd       = f_rsvd_r;
      push_data.dividend   = f_total_r - overhead[31:0];
    end
  end

endmodule

/* sv/fvgc_queue.sv */
// ----------------------------------------------------------------------------
// fvgc_queue
// Short FIFO between the classify front and the divider back end.
// ----------------------------------------------------------------------------
`include "fat_volume_geometry_check_unit_defines.svh"

module fvgc_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fvgc_pkg::entry_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output fvgc_pkg::entry_t head
);
  import fvgc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = store_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  // front must never offer an entry into a full queue
  `FVGC_ASSERT_IMPL(a_no_push_full, clk, rst_n, full, !push)
  `FVGC_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  // fill count rises by one after a push with no pop
  `FVGC_ASSERT_NEXT(a_count_track, clk, rst_n, do_push && !do_pop,
                    count_r == $past(count_r) + 1'b1)

endmodule

/* sv/fvgc_div_stage.sv */
// ----------------------------------------------------------------------------
// fvgc_div_stage
// One registered stage of the restoring divider: DIV_BITS_PER_STAGE quotient bits per stage.
// ----------------------------------------------------------------------------
module fvgc_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           valid_in,
  input  fvgc_pkg::div_t d_in,
  output logic           valid_out,
  output fvgc_pkg::div_t d_out
);
  import fvgc_pkg::*;

  logic [7:0]  rem;
  logic [8:0]  trial;
  logic [31:0] word;
  div_t        step;
  logic        valid_r, valid_nxt;
  div_t        data_r;

  always_comb begin
    rem   = d_in.rem;
    word  = d_in.info.dividend;
    trial = '0;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      trial = {rem, word[31]};
      word  = {word[30:0], 1'b0};
      if (trial >= {1'b0, d_in.info.spc}) begin
        trial   = trial - {1'b0, d_in.info.spc};
        word[0] = 1'b1;
      end
      rem = trial[7:0];
    end
    step               = d_in;
    step.rem           = rem;
    step.info.dividend = word;
  end

  assign valid_nxt = adv ? valid_in : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= step;
    end
  end

  assign valid_out = valid_r;
  assign d_out     = data_r;

endmodule

/* sv/fvgc_back.sv */
// ----------------------------------------------------------------------------
// fvgc_back
// Pulls entries from the queue, runs the pipelined cluster count division,
// picks the FAT type and holds the verdict in the output register.
// ----------------------------------------------------------------------------
module fvgc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  fvgc_pkg::entry_t              head,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // status, fs_type, total_sectors, first_data_sector, root_dir_sectors,
  // cluster_count, cluster_sectors_out, reserved_sectors_out
  output logic [fvgc_pkg::OUT_BITS-1:0] out_tdata
);
  import fvgc_pkg::*;

  logic adv;
  logic stg_v [DIV_STAGES+1];
  div_t stg_d [DIV_STAGES+1];

  logic        out_valid_r, out_valid_nxt;
  status_t     o_status_r;
  fs_type_t    o_type_r, type_sel;
  logic [31:0] o_total_r, o_first_r, o_clusters_r, quo;
  logic [12:0] o_root_r;
  logic [7:0]  o_spc_r;
  logic [15:0] o_rsvd_r;
  entry_t      last;

  // whole back end moves together whenever the output slot frees up
  assign adv = !out_valid_r || out_tready;
  assign pop = adv && head_valid;

  assign stg_v[0]      = head_valid;
  assign stg_d[0].info = head;
  assign stg_d[0].rem  = 8'd0;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    fvgc_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .valid_in  (stg_v[k]),
      .d_in      (stg_d[k]),
      .valid_out (stg_v[k+1]),
      .d_out     (stg_d[k+1])
    );
  end

  assign last = stg_d[DIV_STAGES].info;
  assign quo  = last.dividend;

  always_comb begin
    if (last.status != ST_OK || quo < LIMIT_FAT12) begin
      type_sel = FS_FAT12;
    end else if (quo < LIMIT_FAT16) begin
      type_sel = FS_FAT16;
    end else begin
      type_sel = FS_FAT32;
    end
  end

  assign out_valid_nxt = adv ? stg_v[DIV_STAGES] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && stg_v[DIV_STAGES]) begin
      o_status_r   <= last.status;
      o_type_r     <= type_sel;
      o_total_r    <= last.total;
      o_first_r    <= last.first_data;
      o_root_r     <= last.root;
      o_clusters_r <= (last.status == ST_OK) ? quo : 32'd0;
      o_spc_r      <= last.spc;
      o_rsvd_r     <= last.rsvd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, o_rsvd_r, o_spc_r, o_clusters_r, o_root_r,
                       o_first_r, o_total_r, o_type_r, o_status_r};

endmodule

/* sv/fat_volume_geometry_check_unit.sv */
// Path: front register, queue, divider stages, output register, in that order.
// Throughput: one record per cycle unless out_tready stalls, set by the 8-stage
//   pipelined divider for the cluster count (4 quotient bits per stage).
// Backpressure on the result side fills the queue, then drops in_tready.
// Reset: rst_n synchronous, active low; clears all valid flags and queue pointers.
// ----------------------------------------------------------------------------
// fat_volume_geometry_check_unit
// Checks FAT boot-sector geometry and derives FAT type and cluster count.
// ----------------------------------------------------------------------------
module fat_volume_geometry_check_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // jump_byte0, jump_byte2, bytes_per_sector, root_entry_count, fat_size_short,
  // fat_size_long, total_sectors_short, total_sectors_long,
  // reserved_sector_count, fat_copies, sectors_per_cluster
  input  logic [fvgc_pkg::IN_BITS-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // status, fs_type, total_sectors, first_data_sector, root_dir_sectors,
  // cluster_count, cluster_sectors_out, reserved_sectors_out, zero pad
  output logic [fvgc_pkg::OUT_BITS-1:0] out_tdata
);
  import fvgc_pkg::*;

  logic   push, q_full, q_not_empty, pop;
  entry_t push_data, head;

  fvgc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  fvgc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  fvgc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_not_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
